// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Under synthesis they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent assertion, switched off while the reset is applied.
`define LFU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// Concurrent assertion that is also checked while the reset is applied.
`define LFU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LFU_ASSERT(lbl, clk, rst_n, prop, msg)
`define LFU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int unsigned ID_W  = 7;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned CFG_W = 6;
  // Wide enough to number the cells of the largest supported chain (64).
  localparam int unsigned IDX_W = 6;

  localparam logic [CNT_W-1:0] CNT_SAT         = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 6'd3;

  localparam logic OP_VOTE   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [1:0] {
    CELL_NOP   = 2'd0,
    CELL_HIT   = 2'd1,
    CELL_WRITE = 2'd2
  } cell_op_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_e             op;
    logic [ID_W-1:0]      cmp_id;
    logic [IDX_W-1:0]     tgt_idx;
    logic [ID_W-1:0]      new_id;
    logic [CNT_W-1:0]     new_time;
  } cell_cmd_t;

  // Running victim search, handed from cell to cell once per cycle.
  typedef struct packed {
    logic                 live;
    logic                 found;
    logic [CNT_W-1:0]     best_cnt;
    logic [CNT_W-1:0]     best_time;
    logic [ID_W-1:0]      best_id;
    logic [IDX_W-1:0]     best_idx;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
  } scan_tok_t;

endpackage

// ===== hw/rtl/lfu_cell.sv =====
`timescale 1ns / 1ps

// One frame: holds a resident id with its hit count and insertion time, and
// folds itself into the victim search token as it passes by.
module lfu_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfu_pkg::cell_cmd_t   cmd_i,
  input  lfu_pkg::scan_tok_t   tok_i,
  output lfu_pkg::scan_tok_t   tok_o,
  output logic                 valid_o,
  output logic                 match_o
);

  localparam logic [lfu_pkg::IDX_W-1:0] MY_IDX = lfu_pkg::IDX_W'(CELL_IDX);

  logic                        valid_q;
  logic [lfu_pkg::ID_W-1:0]    id_q;
  logic [lfu_pkg::CNT_W-1:0]   cnt_q;
  logic [lfu_pkg::CNT_W-1:0]   time_q;
  logic                        sel;
  lfu_pkg::scan_tok_t          tok_d, tok_q;

  assign match_o = valid_q && (id_q == cmd_i.cmp_id);
  assign sel     = (cmd_i.op == lfu_pkg::CELL_WRITE) && (cmd_i.tgt_idx == MY_IDX);
  assign valid_o = valid_q;
  assign tok_o   = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      lfu_pkg::CELL_HIT: begin
        if (match_o && (cnt_q != lfu_pkg::CNT_SAT)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      lfu_pkg::CELL_WRITE: begin
        if (sel) begin
          id_q   <= cmd_i.new_id;
          cnt_q  <= lfu_pkg::CNT_W'(1);
          time_q <= cmd_i.new_time;
        end
      end
      default: begin
      end
    endcase
  end

  // Lowest (count, insertion time, id) wins; the first free cell is noted too.
  always_comb begin
    tok_d = tok_i;
    if (valid_q) begin
      if (!tok_i.found ||
          ({cnt_q, time_q, id_q} < {tok_i.best_cnt, tok_i.best_time, tok_i.best_id})) begin
        tok_d.found     = 1'b1;
        tok_d.best_cnt  = cnt_q;
        tok_d.best_time = time_q;
        tok_d.best_id   = id_q;
        tok_d.best_idx  = MY_IDX;
      end
    end else if (!tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

endmodule

// ===== hw/rtl/lfu_slot_replacement_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: opcode; tdata: candidate_id
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: vote and report fields; tlast
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i: frame_count
//
// A vote that hits passes through the decide and emit states before its result
// enters the output register, and the next transaction is taken once the controller
// is back in idle. A miss also waits in the search state while the victim search
// token walks the chain of frame cells one cell per cycle. A report steps through the
// ids in ascending order, one id per cycle unless a resident id meets a stalled
// output. The reset is asynchronous and active low and leaves all frames empty; there
// is no clearing pass. A stalled output holds the current result and, during a
// report, freezes the id scan on the next resident id.
module lfu_slot_replacement_core #(
  parameter int unsigned NUM_IDS    = 128,
  parameter int unsigned MAX_FRAMES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input transactions.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] candidate_id, [7] zero
  input  logic        s_axis_tuser,   // [0] opcode
  // Result transactions.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] was_hit, [1] evicted_valid,
                                      // [8:2] evicted_id, [9] occupant_valid,
                                      // [16:10] occupant_id, [23:17] zero
  output logic        m_axis_tlast,
  // Configuration: frame_count.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  localparam int unsigned FW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IW = lfu_pkg::ID_W;
  localparam int unsigned CW = lfu_pkg::CNT_W;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_REPORT = 5'b10000
  } state_e;

  state_e                state_d, state_q;
  logic                  op_d, op_q;
  logic [IW-1:0]         id_d, id_q;
  logic [CW-1:0]         vote_d, vote_q;
  logic [CW-1:0]         now_d, now_q;
  logic [FW-1:0]         total_d, total_q;
  logic [FW-1:0]         emitted_d, emitted_q;
  logic [IW-1:0]         scan_d, scan_q;
  logic [5:0]            frame_count_q;
  logic                  res_hit_d, res_hit_q;
  logic                  res_ev_d, res_ev_q;
  logic [IW-1:0]         res_evid_d, res_evid_q;

  logic                  m_valid_d, m_valid_q;
  logic                  out_hit_q, out_ev_q, out_ov_q, out_last_q;
  logic [IW-1:0]         out_evid_q, out_oid_q;

  logic                  push, push_hit, push_ev, push_ov, push_last;
  logic [IW-1:0]         push_evid, push_oid;
  logic                  out_free;
  logic                  id_ok;
  logic                  any_match;
  logic [FW-1:0]         frames_eff;

  lfu_pkg::cell_cmd_t    cmd;
  lfu_pkg::scan_tok_t    tok [MAX_FRAMES+1];
  logic [MAX_FRAMES-1:0] cell_valid;
  logic [MAX_FRAMES-1:0] cell_match;

  // The chain of frame cells. The search token enters at cell 0 and passes
  // through the token register of every cell before it leaves the last cell.
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lfu_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .valid_o (cell_valid[g]),
      .match_o (cell_match[g])
    );
  end

  assign any_match = |cell_match;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign id_ok     = int'(id_q) < NUM_IDS;

  // A frame count of zero behaves as one; anything above MAX_FRAMES is capped.
  always_comb begin
    if (int'(frame_count_q) > MAX_FRAMES) begin
      frames_eff = FW'(MAX_FRAMES);
    end else if (frame_count_q == '0) begin
      frames_eff = FW'(1);
    end else begin
      frames_eff = FW'(frame_count_q);
    end
  end

  // The search token is launched empty when a vote misses.
  always_comb begin
    tok[0]      = '0;
    tok[0].live = (state_q == ST_DECIDE) && (op_q == lfu_pkg::OP_VOTE) && id_ok &&
                  !any_match;
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_d       = id_q;
    vote_d     = vote_q;
    now_d      = now_q;
    total_d    = total_q;
    emitted_d  = emitted_q;
    scan_d     = scan_q;
    res_hit_d  = res_hit_q;
    res_ev_d   = res_ev_q;
    res_evid_d = res_evid_q;

    push      = 1'b0;
    push_hit  = 1'b0;
    push_ev   = 1'b0;
    push_evid = '0;
    push_ov   = 1'b0;
    push_oid  = '0;
    push_last = 1'b0;

    cmd          = '0;
    cmd.op       = lfu_pkg::CELL_NOP;
    cmd.cmp_id   = (state_q == ST_REPORT) ? scan_q : id_q;
    cmd.new_id   = id_q;
    cmd.new_time = now_q;

    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = s_axis_tuser;
          id_d    = s_axis_tdata[IW-1:0];
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_hit_d  = 1'b0;
        res_ev_d   = 1'b0;
        res_evid_d = '0;
        if (op_q == lfu_pkg::OP_REPORT) begin
          if (total_q == '0) begin
            // Nothing resident: one empty result closes the report.
            state_d = ST_EMIT;
          end else begin
            scan_d    = '0;
            emitted_d = '0;
            state_d   = ST_REPORT;
          end
        end else if (!id_ok) begin
          // Out-of-range ids are ignored and do not count as votes.
          state_d = ST_EMIT;
        end else begin
          if (vote_q != lfu_pkg::CNT_SAT) begin
            vote_d = vote_q + 1'b1;
          end
          if (any_match) begin
            cmd.op    = lfu_pkg::CELL_HIT;
            res_hit_d = 1'b1;
            state_d   = ST_EMIT;
          end else begin
            now_d   = vote_q;
            state_d = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (tok[MAX_FRAMES].live) begin
          cmd.op = lfu_pkg::CELL_WRITE;
          if (total_q >= frames_eff) begin
            // No free frame: the new id takes over the victim's cell.
            cmd.tgt_idx = tok[MAX_FRAMES].best_idx;
            res_ev_d    = 1'b1;
            res_evid_d  = tok[MAX_FRAMES].best_id;
          end else begin
            cmd.tgt_idx = tok[MAX_FRAMES].free_idx;
            total_d     = total_q + FW'(1);
          end
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          push      = 1'b1;
          push_hit  = res_hit_q;
          push_ev   = res_ev_q;
          push_evid = res_evid_q;
          push_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      ST_REPORT: begin
        if (any_match) begin
          if (out_free) begin
            push      = 1'b1;
            push_ov   = 1'b1;
            push_oid  = scan_q;
            push_last = (emitted_q == (total_q - FW'(1)));
            emitted_d = emitted_q + FW'(1);
            scan_d    = scan_q + 1'b1;
            if (push_last) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      vote_q        <= '0;
      total_q       <= '0;
      emitted_q     <= '0;
      frame_count_q <= lfu_pkg::FRAME_COUNT_RST;
      m_valid_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      vote_q    <= vote_d;
      total_q   <= total_d;
      emitted_q <= emitted_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        frame_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    now_q      <= now_d;
    scan_q     <= scan_d;
    res_hit_q  <= res_hit_d;
    res_ev_q   <= res_ev_d;
    res_evid_q <= res_evid_d;
    if (push) begin
      out_hit_q  <= push_hit;
      out_ev_q   <= push_ev;
      out_evid_q <= push_evid;
      out_ov_q   <= push_ov;
      out_oid_q  <= push_oid;
      out_last_q <= push_last;
    end
  end

  // The output register holds a result until the downstream side takes it.
  assign m_valid_d = push || (m_valid_q && !m_axis_tready);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, out_oid_q, out_ov_q, out_evid_q, out_ev_q, out_hit_q};
  assign m_axis_tlast  = out_last_q;
  assign cfg_ready_o   = 1'b1;

  // The resident total always agrees with the occupied cells.
  `LFU_ASSERT(a_total_cells, clk_i, rst_ni, $countones(cell_valid) == int'(total_q), "bad total")
  // A search token only reaches the chain end while the controller waits for it.
  `LFU_ASSERT(a_tok_search, clk_i, rst_ni, tok[MAX_FRAMES].live |-> state_q == ST_SEARCH, "stray token")
  // Resident ids are unique, so at most one cell can match.
  `LFU_ASSERT(a_unique_match, clk_i, rst_ni, $onehot0(cell_match), "duplicate resident id")
  // A report never lists more ids than are resident.
  `LFU_ASSERT(a_report_bound, clk_i, rst_ni, (state_q == ST_REPORT) |-> (emitted_q < total_q), "report overrun")
  // No result is offered while the reset is applied.
  `LFU_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "result during reset")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned N_IDS    = 128;
  localparam int unsigned N_FRAMES = 32;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic                     was_hit;
    logic                     evicted_valid;
    logic [lfu_pkg::ID_W-1:0] evicted_id;
    logic                     occupant_valid;
    logic [lfu_pkg::ID_W-1:0] occupant_id;
    logic                     last;
  } outcome_t;

  // Scoreboard: keeps its own copy of the frame table and predicts the
  // result transactions of every accepted request, oldest first.
  class frame_scoreboard;
    bit                        resident[N_IDS];
    logic [lfu_pkg::CNT_W-1:0] hit_count[N_IDS];
    logic [lfu_pkg::CNT_W-1:0] insert_time[N_IDS];
    int unsigned               occupied;
    logic [lfu_pkg::CNT_W-1:0] vote_clock;
    logic [lfu_pkg::CFG_W-1:0] frame_cfg;
    outcome_t                  due_outcomes[$];
    int unsigned               errors, checked, votes, hits, evictions, reports;

    function new();
      foreach (resident[j]) begin
        resident[j]    = 1'b0;
        hit_count[j]   = '0;
        insert_time[j] = '0;
      end
      occupied  = 0;
      vote_clock = '0;
      frame_cfg = lfu_pkg::FRAME_COUNT_RST;
      errors    = 0;
      checked   = 0;
      votes     = 0;
      hits      = 0;
      evictions = 0;
      reports   = 0;
    endfunction

    function void set_frames(logic [lfu_pkg::CFG_W-1:0] v);
      frame_cfg = v;
    endfunction

    function int unsigned outstanding();
      return due_outcomes.size();
    endfunction

    // A setting of zero behaves as one frame; anything above the maximum is clipped.
    function int unsigned frames_usable();
      if (frame_cfg == 0) return 1;
      if (frame_cfg > N_FRAMES) return N_FRAMES;
      return frame_cfg;
    endfunction

    function void note_request(logic op, logic [lfu_pkg::ID_W-1:0] id);
      outcome_t                  o;
      int unsigned               total, listed;
      int                        best, j;
      logic [lfu_pkg::CNT_W-1:0] now;
      o = '0;
      if (op == lfu_pkg::OP_REPORT) begin
        reports++;
        total = 0;
        foreach (resident[k]) if (resident[k]) total++;
        if (total > N_FRAMES) total = N_FRAMES;
        if (total == 0) begin
          // Nothing resident: a single empty entry closes the report.
          o.last = 1'b1;
          due_outcomes.push_back(o);
          return;
        end
        listed = 0;
        for (j = 0; j < N_IDS && listed < total; j++) begin
          if (resident[j]) begin
            o.occupant_valid = 1'b1;
            o.occupant_id    = j[lfu_pkg::ID_W-1:0];
            o.last           = (listed == total - 1);
            due_outcomes.push_back(o);
            listed++;
          end
        end
        return;
      end

      o.last = 1'b1;
      if (id >= N_IDS) begin
        due_outcomes.push_back(o);
        return;
      end
      votes++;
      now = vote_clock;
      if (vote_clock != lfu_pkg::CNT_SAT) vote_clock++;
      if (resident[id]) begin
        o.was_hit = 1'b1;
        hits++;
        if (hit_count[id] != lfu_pkg::CNT_SAT) hit_count[id]++;
      end else begin
        if (occupied >= frames_usable()) begin
          // Victim: fewest hits, then oldest insertion, then lowest id.
          best = -1;
          for (j = 0; j < N_IDS; j++) begin
            if (resident[j] && (best < 0 || hit_count[j] < hit_count[best] ||
                (hit_count[j] == hit_count[best] && insert_time[j] < insert_time[best])))
              best = j;
          end
          if (best >= 0) begin
            resident[best]  = 1'b0;
            hit_count[best] = '0;
            o.evicted_valid = 1'b1;
            o.evicted_id    = best[lfu_pkg::ID_W-1:0];
            occupied--;
            evictions++;
          end
        end
        resident[id]    = 1'b1;
        hit_count[id]   = lfu_pkg::CNT_W'(1);
        insert_time[id] = now;
        occupied++;
      end
      due_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] data, logic tlast);
      outcome_t want;
      if (due_outcomes.size() == 0) begin
        $error("result with no request outstanding: tdata %h tlast %b", data, tlast);
        errors++;
        return;
      end
      want = due_outcomes.pop_front();
      checked++;
      compare_field("was_hit", want.was_hit, data[0]);
      compare_field("evicted_valid", want.evicted_valid, data[1]);
      compare_field("evicted_id", want.evicted_id, data[8:2]);
      compare_field("occupant_valid", want.occupant_valid, data[9]);
      compare_field("occupant_id", want.occupant_id, data[16:10]);
      compare_field("last", want.last, tlast);
    endfunction
  endclass

  logic                      clk_i         = 1'b0;
  logic                      rst_ni;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;   // [6:0] candidate_id, [7] zero
  logic                      s_axis_tuser  = 1'b0; // [0] opcode
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [23:0]               m_axis_tdata;         // [0] was_hit, [1] evicted_valid,
                                                   // [8:2] evicted_id,
                                                   // [9] occupant_valid,
                                                   // [16:10] occupant_id, [23:17] zero
  logic                      m_axis_tlast;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [lfu_pkg::CFG_W-1:0] cfg_data_i    = lfu_pkg::FRAME_COUNT_RST;

  frame_scoreboard   sb;
  bit                idling    = 1'b1;  // random gaps on both sides when set
  int unsigned       sink_hold = 0;     // one-off long hold-off of the result side

  lfu_slot_replacement_core #(
    .NUM_IDS    (N_IDS),
    .MAX_FRAMES (N_FRAMES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Inputs move on the falling edge; handshakes are judged on the rising edge,
  // where the block's outputs still hold their pre-edge values.
  task automatic offer_request(logic op, logic [lfu_pkg::ID_W-1:0] id);
    int unsigned gap;
    gap = idling ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {1'b0, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, id);
  endtask

  // Stops offering requests and waits until every predicted result has arrived.
  task automatic await_drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // The frame count is only changed while the block is idle.
  task automatic write_frame_count(logic [lfu_pkg::CFG_W-1:0] v);
    await_drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_frames(v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Result side: draws a stall before each transaction, or serves the long
  // hold-off when one has been requested, then checks what it accepts.
  initial begin : result_sink
    int unsigned pause;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      pause = (sink_hold != 0) ? sink_hold : (idling ? $urandom_range(0, 7) : 0);
      sink_hold = 0;
      if (pause != 0) begin
        m_axis_tready = 1'b0;
        repeat (pause) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin : stimulus
    logic [lfu_pkg::CFG_W-1:0] phase_frames [7];
    logic [lfu_pkg::CFG_W-1:0] setting;
    int unsigned               usable, pool_base, pool_size, k, p;
    logic                      op;
    logic [lfu_pkg::ID_W-1:0]  id;
    phase_frames = '{6'd32, 6'd2, 6'd63, 6'd0, 6'd9, 6'd1, 6'd20};
    sb = new();
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset frame count of three: an empty report,
    // fills, a hit, an eviction decided by the oldest insertion among equal
    // counts, then shrinking the frame count below the number of residents.
    offer_request(lfu_pkg::OP_REPORT, 7'd127);
    offer_request(lfu_pkg::OP_VOTE, 7'd0);
    offer_request(lfu_pkg::OP_VOTE, 7'd127);
    offer_request(lfu_pkg::OP_VOTE, 7'd0);
    offer_request(lfu_pkg::OP_VOTE, 7'd85);
    offer_request(lfu_pkg::OP_VOTE, 7'd42);
    offer_request(lfu_pkg::OP_REPORT, 7'd0);
    offer_request(lfu_pkg::OP_VOTE, 7'd85);
    write_frame_count(6'd1);
    offer_request(lfu_pkg::OP_VOTE, 7'd127);
    offer_request(lfu_pkg::OP_REPORT, 7'd85);
    write_frame_count(6'd0);
    offer_request(lfu_pkg::OP_VOTE, 7'd1);
    offer_request(lfu_pkg::OP_VOTE, 7'd1);
    write_frame_count(6'd63);
    offer_request(lfu_pkg::OP_VOTE, 7'd2);
    offer_request(lfu_pkg::OP_VOTE, 7'd3);
    offer_request(lfu_pkg::OP_VOTE, 7'd4);
    offer_request(lfu_pkg::OP_VOTE, 7'd126);
    offer_request(lfu_pkg::OP_REPORT, 7'd42);
    write_frame_count(6'd32);
    offer_request(lfu_pkg::OP_VOTE, 7'd106);
    offer_request(lfu_pkg::OP_REPORT, 7'd21);

    // Random phases. Most votes come from a pool a little larger than the
    // usable frames, so hits and evictions both stay frequent.
    for (p = 0; p < 7; p++) begin
      setting = (p == 6) ? lfu_pkg::CFG_W'($urandom_range(0, 63)) : phase_frames[p];
      write_frame_count(setting);
      usable    = (setting == 0) ? 1 : (setting > N_FRAMES) ? N_FRAMES : setting;
      pool_base = $urandom_range(0, N_IDS - 1);
      pool_size = usable + 1 + $urandom_range(0, usable);
      idling    = (p != 4);
      for (k = 0; k < 52; k++) begin
        if (p == 1 && k == 26) await_drain();
        if (p == 2 && k == 20) begin
          // Long hold-off on the result side while requests keep coming
          // back to back, so that the block backs up into its input.
          idling    = 1'b0;
          sink_hold = 300;
        end
        if (p == 2 && k == 36) idling = 1'b1;
        op = ($urandom_range(0, 99) < 12) ? lfu_pkg::OP_REPORT : lfu_pkg::OP_VOTE;
        if (op == lfu_pkg::OP_VOTE && $urandom_range(0, 99) < 75)
          id = lfu_pkg::ID_W'((pool_base + $urandom_range(0, pool_size - 1)) % N_IDS);
        else
          id = lfu_pkg::ID_W'($urandom_range(0, N_IDS - 1));
        offer_request(op, id);
      end
    end

    await_drain();
    repeat (N_FRAMES + 8) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      $error("%0d expected results never arrived", sb.outstanding());
      sb.errors++;
    end
    $display("Run covered %0d votes (%0d hits, %0d evictions) and %0d reports.",
             sb.votes, sb.hits, sb.evictions, sb.reports);
    $display("%0d results checked; frame counts 0, 1, 2, 3, 9, 32, 63 and %0d %s",
             sb.checked, setting, "were used, with drain pauses and a long output hold-off.");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #10ms;
    $error("run did not finish in time");
    $display("status: fail");
    $finish;
  end

endmodule
